/* rtl/sda_pkg.sv */
// package for the spring-damper axis step block
// holds item structs, configuration and state structs, register indexes and constants
// no dependencies
`default_nettype none

package sda_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned AddrW = 5;

  localparam logic [DataW-1:0] OneFp     = 32'h0001_0000;
  localparam logic [DataW-1:0] FoldBit   = 32'h0800_0000;
  localparam logic [DataW-1:0] FoldHigh  = 32'hF000_0000;
  localparam logic [DataW-1:0] FoldLow   = 32'h0FFF_FFFF;

  localparam logic [DataW-1:0] StiffnessRst = 32'h0000_0000;
  localparam logic [DataW-1:0] DampingRst   = OneFp;
  localparam logic [DataW-1:0] PosMinRst    = 32'h8000_0000;
  localparam logic [DataW-1:0] PosMaxRst    = 32'h7FFF_FFFF;
  localparam logic [DataW-1:0] TargetRst    = 32'h0000_0000;

  typedef enum logic [2:0] {
    REG_STIFFNESS = 3'd0,
    REG_DAMPING   = 3'd1,
    REG_POS_MIN   = 3'd2,
    REG_POS_MAX   = 3'd3,
    REG_TARGET    = 3'd4
  } reg_idx_e;

  typedef enum logic {
    MODE_IMPULSE = 1'b0,
    MODE_TICK    = 1'b1
  } mode_e;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] impulse;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] position_out;
    logic signed [31:0] velocity_out;
    logic signed [31:0] accel_out;
    logic               clamped;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] stiffness;
    logic signed [31:0] damping;
    logic signed [31:0] pos_min;
    logic signed [31:0] pos_max;
    logic signed [31:0] target;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic signed [31:0] accel;
    logic signed [31:0] pending;
  } axis_state_t;

endpackage

`default_nettype wire

/* rtl/sda_cfg.sv */
// configuration register file behind an apb-style port
// depends on sda_pkg
`default_nettype none

module sda_cfg
  import sda_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  reg_idx_e   idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_STIFFNESS: cfg_d.stiffness = pwdata;
        REG_DAMPING:   cfg_d.damping   = pwdata;
        REG_POS_MIN:   cfg_d.pos_min   = pwdata;
        REG_POS_MAX:   cfg_d.pos_max   = pwdata;
        REG_TARGET:    cfg_d.target    = pwdata;
        default:       cfg_d           = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_STIFFNESS: prdata = cfg_q.stiffness;
      REG_DAMPING:   prdata = cfg_q.damping;
      REG_POS_MIN:   prdata = cfg_q.pos_min;
      REG_POS_MAX:   prdata = cfg_q.pos_max;
      REG_TARGET:    prdata = cfg_q.target;
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stiffness <= StiffnessRst;
      cfg_q.damping   <= DampingRst;
      cfg_q.pos_min   <= PosMinRst;
      cfg_q.pos_max   <= PosMaxRst;
      cfg_q.target    <= TargetRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/sda_step.sv */
// one euler step of the axis: impulse accumulate or tick with fold and clamp
// depends on sda_pkg
`default_nettype none

module sda_step
  import sda_pkg::*;
(
  input  wire cfg_t        cfg_i,
  input  wire axis_state_t state_i,
  input  wire in_item_t    item_i,
  output axis_state_t      state_o,
  output out_item_t        result_o
);

  logic signed [31:0] pos_err;
  logic signed [31:0] damp_gain;
  logic signed [63:0] spring_prod;
  logic signed [63:0] damp_prod;
  logic signed [31:0] accel_new;
  logic signed [31:0] vel_sum;
  logic signed [31:0] pos_sum;
  logic signed [31:0] pos_fold;
  axis_state_t        nxt;
  logic               hit;

  assign pos_err     = cfg_i.target - state_i.position;
  assign damp_gain   = OneFp - cfg_i.damping;
  assign spring_prod = 64'(cfg_i.stiffness) * 64'(pos_err);
  assign damp_prod   = 64'(damp_gain) * 64'(state_i.velocity);
  assign accel_new   = spring_prod[47:16] - damp_prod[47:16] + state_i.pending;
  assign vel_sum     = state_i.velocity + accel_new;
  assign pos_sum     = state_i.position + vel_sum;
  assign pos_fold    = ((pos_sum & FoldBit) != '0) ? (pos_sum | FoldHigh)
                                                   : (pos_sum & FoldLow);

  always_comb begin
    nxt = state_i;
    hit = 1'b0;
    if (mode_e'(item_i.mode) == MODE_IMPULSE) begin
      nxt.pending = state_i.pending + item_i.impulse;
    end else begin
      nxt.accel    = accel_new;
      nxt.velocity = vel_sum;
      nxt.position = pos_fold;
      nxt.pending  = '0;
      if (pos_fold > cfg_i.pos_max) begin
        nxt.position = cfg_i.pos_max;
        nxt.velocity = '0;
        hit          = 1'b1;
      end else if (pos_fold < cfg_i.pos_min) begin
        nxt.position = cfg_i.pos_min;
        nxt.velocity = '0;
        hit          = 1'b1;
      end
    end
  end

  assign state_o               = nxt;
  assign result_o.position_out = nxt.position;
  assign result_o.velocity_out = nxt.velocity;
  assign result_o.accel_out    = nxt.accel;
  assign result_o.clamped      = hit;

endmodule

`default_nettype wire

/* rtl/spring_damper_axis_step_core.sv */
// top level of one spring-damper axis: input register, step logic, result register
// depends on sda_pkg, sda_cfg and sda_step
//
// usage:
//   input channel in_valid_i/in_ready_o/in_data_i carries an item of mode and impulse.
//   mode impulse adds the impulse to a pending sum, mode tick advances the axis once.
//   output channel out_valid_o/out_ready_i/out_data_o returns one result per item:
//   position, velocity, acceleration of the last tick and the clamp flag.
//   apb-style port sets stiffness, damping, limits and target (byte address 4*index);
//   write it only while no item is in flight. pready is always high.
// timing:
//   an item is taken into the input register, then the step logic runs against the
//   axis state and the result lands in the output register. one item per cycle is
//   sustained while results are taken; the rate is set by the loop of two 32x32
//   multiplies, sums, fold and clamp on the state.
// reset:
//   state is zero, registers take their reset values, both stages are empty.
// stall:
//   a held result keeps the output register; one more item waits in the input register
//   and in_ready_o drops until the result is taken.
`default_nettype none

module spring_damper_axis_step_core
  import sda_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire in_item_t         in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output out_item_t             out_data_o,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready
);

  cfg_t        cfg;
  axis_state_t state_q, state_d;
  in_item_t    item_q;
  logic        item_vld_q;
  out_item_t   res_q, res_d;
  logic        res_vld_q;
  logic        advance;

  sda_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sda_step u_step (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  assign advance     = item_vld_q & (~res_vld_q | out_ready_i);
  assign in_ready_o  = ~item_vld_q | advance;
  assign out_valid_o = res_vld_q;
  assign out_data_o  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
      state_q    <= '0;
    end else begin
      if (in_ready_o) begin
        item_vld_q <= in_valid_i;
      end
      if (advance) begin
        res_vld_q <= 1'b1;
        state_q   <= state_d;
      end else if (out_ready_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_data_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

endmodule

`default_nettype wire

/* dv/spring_damper_axis_step_checker.sv */
// checker for the spring-damper axis step core: watches the item channels and the apb port,
// predicts each result from its own copy of axis state and registers, and counts mismatches
// depends on sda_pkg
module spring_damper_axis_step_checker
  import sda_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  in_item_t         in_data_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  out_item_t        out_data_i,
  input  logic             psel_i,
  input  logic             penable_i,
  input  logic             pwrite_i,
  input  logic             pready_i,
  input  logic [AddrW-1:0] paddr_i,
  input  logic [DataW-1:0] pwdata_i,
  output int unsigned      fail_count_o,
  output int unsigned      results_waiting_o,
  output int unsigned      clamp_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t        axis_cfg;
  axis_state_t axis_now;
  out_item_t   axis_results_q[$];

  task automatic flag_error(input string msg);
    if (fail_count_o < 40) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
    fail_count_o++;
  endtask

  // 16.16 product, floor of the shifted 64-bit value
  function automatic logic [31:0] fixed_mul(input logic [31:0] a, input logic [31:0] b);
    logic signed [63:0] prod;
    prod = 64'($signed(a)) * 64'($signed(b));
    return prod[47:16];
  endfunction

  function automatic out_item_t step_axis(input in_item_t item);
    out_item_t   res;
    logic [31:0] spring;
    logic [31:0] damp;
    logic        hit;
    hit = 1'b0;
    if (item.mode == MODE_IMPULSE) begin
      axis_now.pending = axis_now.pending + item.impulse;
    end else begin
      spring = fixed_mul(axis_cfg.stiffness, axis_cfg.target - axis_now.position);
      damp   = fixed_mul(OneFp - axis_cfg.damping, axis_now.velocity);
      axis_now.accel    = spring - damp + axis_now.pending;
      axis_now.velocity = axis_now.velocity + axis_now.accel;
      axis_now.position = axis_now.position + axis_now.velocity;
      if ((axis_now.position & FoldBit) != '0) begin
        axis_now.position = axis_now.position | FoldHigh;
      end else begin
        axis_now.position = axis_now.position & FoldLow;
      end
      // upper limit wins when the limits are crossed
      if (axis_now.position > axis_cfg.pos_max) begin
        axis_now.position = axis_cfg.pos_max;
        axis_now.velocity = '0;
        hit = 1'b1;
      end else if (axis_now.position < axis_cfg.pos_min) begin
        axis_now.position = axis_cfg.pos_min;
        axis_now.velocity = '0;
        hit = 1'b1;
      end
      axis_now.pending = '0;
      if (hit) begin
        clamp_count_o++;
      end
    end
    res.position_out = axis_now.position;
    res.velocity_out = axis_now.velocity;
    res.accel_out    = axis_now.accel;
    res.clamped      = hit;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_item_t want;
    if (!rst_ni) begin
      axis_cfg.stiffness = StiffnessRst;
      axis_cfg.damping   = DampingRst;
      axis_cfg.pos_min   = PosMinRst;
      axis_cfg.pos_max   = PosMaxRst;
      axis_cfg.target    = TargetRst;
      axis_now = '0;
      axis_results_q.delete();
      results_waiting_o = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[AddrW-1:2]))
          REG_STIFFNESS: axis_cfg.stiffness = pwdata_i;
          REG_DAMPING:   axis_cfg.damping   = pwdata_i;
          REG_POS_MIN:   axis_cfg.pos_min   = pwdata_i;
          REG_POS_MAX:   axis_cfg.pos_max   = pwdata_i;
          REG_TARGET:    axis_cfg.target    = pwdata_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (axis_results_q.size() == 0) begin
          flag_error("result item with nothing expected");
        end else begin
          want = axis_results_q.pop_front();
          if (out_data_i.position_out !== want.position_out) begin
            flag_error($sformatf("position expected %h got %h",
                                 want.position_out, out_data_i.position_out));
          end
          if (out_data_i.velocity_out !== want.velocity_out) begin
            flag_error($sformatf("velocity expected %h got %h",
                                 want.velocity_out, out_data_i.velocity_out));
          end
          if (out_data_i.accel_out !== want.accel_out) begin
            flag_error($sformatf("accel expected %h got %h",
                                 want.accel_out, out_data_i.accel_out));
          end
          if (out_data_i.clamped !== want.clamped) begin
            flag_error($sformatf("clamped expected %b got %b",
                                 want.clamped, out_data_i.clamped));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        axis_results_q.push_back(step_axis(in_data_i));
      end
      results_waiting_o = axis_results_q.size();
    end
  end

endmodule

/* dv/spring_damper_axis_step_core_test.sv */
// testbench top for the spring-damper axis step core: clock, reset, item and register stimulus
// with bursty sending and a stalling receiver, and the final verdict
// depends on sda_pkg, spring_damper_axis_step_core and spring_damper_axis_step_checker
module spring_damper_axis_step_core_test
  import sda_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid;
  logic             in_ready;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_ready;
  out_item_t        out_data;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  int unsigned fail_count;
  int unsigned results_waiting;
  int unsigned clamp_count;
  int unsigned burst_left;
  int unsigned tick_count;
  int unsigned impulse_count;
  int unsigned setting_count;

  spring_damper_axis_step_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  spring_damper_axis_step_checker i_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .in_data_i         (in_data),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .out_data_i        (out_data),
    .psel_i            (psel),
    .penable_i         (penable),
    .pwrite_i          (pwrite),
    .pready_i          (pready),
    .paddr_i           (paddr),
    .pwdata_i          (pwdata),
    .fail_count_o      (fail_count),
    .results_waiting_o (results_waiting),
    .clamp_count_o     (clamp_count)
  );

  initial begin : clock_gen
    forever begin
      #4 clk_i = ~clk_i;
    end
  end

  initial begin : watchdog
    #4_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin : drain_pattern
    int unsigned span;
    int unsigned style;
    out_ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      style = $urandom_range(0, 3);
      span  = $urandom_range(8, 120);
      repeat (span) begin
        @(negedge clk_i);
        case (style)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 1) == 1);
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ~out_ready;
        endcase
      end
    end
  end

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_item(input mode_e m, input logic [31:0] imp);
    in_item_t    item;
    int unsigned gap;
    item.mode    = m;
    item.impulse = imp;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk_i); while (!in_ready);
    if (m == MODE_TICK) begin
      tick_count++;
    end else begin
      impulse_count++;
    end
  endtask

  // drop valid and wait for every outstanding result
  task automatic settle();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (results_waiting != 0) @(negedge clk_i);
  endtask

  function automatic logic [31:0] corner_or(input logic [31:0] usual);
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return $urandom();
      default: return usual;
    endcase
  endfunction

  initial begin : stimulus
    logic [31:0] rest;
    logic [31:0] reach;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] swap;
    logic [31:0] imp;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    burst_left    = 0;
    tick_count    = 0;
    impulse_count = 0;
    setting_count = 1;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: pending sum wraps, tick ignores its impulse field
    send_item(MODE_TICK, 32'h0000_0000);
    send_item(MODE_IMPULSE, 32'h7FFF_FFFF);
    send_item(MODE_IMPULSE, 32'h7FFF_FFFF);
    send_item(MODE_TICK, 32'hFFFF_FFFF);
    send_item(MODE_IMPULSE, 32'h8000_0000);
    send_item(MODE_TICK, 32'h0000_0000);

    // extreme gains, one minus damping overflows
    settle();
    write_reg(REG_STIFFNESS, 32'h7FFF_FFFF);
    write_reg(REG_DAMPING, 32'h8000_0000);
    write_reg(REG_TARGET, 32'h8000_0000);
    setting_count++;
    send_item(MODE_TICK, 32'h0000_0000);
    send_item(MODE_TICK, 32'h0000_0000);
    send_item(MODE_IMPULSE, 32'h0001_0000);
    send_item(MODE_TICK, 32'h0000_0000);

    // crossed limits
    settle();
    write_reg(REG_POS_MIN, 32'h0010_0000);
    write_reg(REG_POS_MAX, 32'hFFF0_0000);
    write_reg(REG_STIFFNESS, 32'h0000_8000);
    write_reg(REG_DAMPING, 32'h0000_8000);
    write_reg(REG_TARGET, 32'h0000_0000);
    setting_count++;
    send_item(MODE_TICK, 32'h0000_0000);
    send_item(MODE_IMPULSE, 32'h0200_0000);
    send_item(MODE_TICK, 32'h0000_0000);

    // lower limit hit, then pushed toward the top
    settle();
    write_reg(REG_POS_MIN, 32'h0000_0000);
    write_reg(REG_POS_MAX, 32'h7FFF_FFFF);
    write_reg(REG_STIFFNESS, 32'h8000_0000);
    write_reg(REG_TARGET, 32'h7FFF_FFFF);
    setting_count++;
    send_item(MODE_IMPULSE, 32'h8000_0000);
    send_item(MODE_TICK, 32'h0000_0000);
    send_item(MODE_IMPULSE, 32'h07FF_FFFF);
    send_item(MODE_TICK, 32'h0000_0000);
    send_item(MODE_TICK, 32'h0000_0000);

    for (int phase = 0; phase < 8; phase++) begin
      settle();
      rest  = $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
      reach = $urandom_range(32'h0001_0000, 32'h0200_0000);
      lo    = rest - reach;
      hi    = rest + reach;
      if ($urandom_range(0, 7) == 0) begin
        swap = lo;
        lo   = hi;
        hi   = swap;
      end
      write_reg(REG_STIFFNESS, corner_or($urandom_range(0, 32'h0000_6000)));
      write_reg(REG_DAMPING, corner_or($urandom_range(0, 32'h0001_0000)));
      write_reg(REG_POS_MIN, corner_or(lo));
      write_reg(REG_POS_MAX, corner_or(hi));
      write_reg(REG_TARGET, corner_or(rest));
      setting_count++;
      repeat (94) begin
        if ($urandom_range(0, 5) == 0) begin
          imp = $urandom();
        end else begin
          imp = $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
        end
        if ($urandom_range(0, 19) < 11) begin
          send_item(MODE_TICK, imp);
        end else begin
          send_item(MODE_IMPULSE, imp);
        end
      end
    end

    settle();
    repeat (8) @(negedge clk_i);
    $display("covered %0d items: %0d ticks (%0d clamped) and %0d impulses",
             tick_count + impulse_count, tick_count, clamp_count, impulse_count);
    $display("over %0d register settings with extreme gains, crossed limits and wrapping sums",
             setting_count);
    if (fail_count == 0 && results_waiting == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
